// ----- rtl/hsdr_pkg.sv -----
`timescale 1ns / 1ps
package hsdr_pkg;

  localparam int CORDIC_STAGES = 16;
  // The angle table has 24 entries; more stages than that add nothing.
  localparam int CORDIC_ITERS  = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam int ITER_W        = 5;

  localparam int CNT_W         = 6;
  localparam int RATE_STEPS    = 16;
  localparam int DISP_STEPS    = 32;

  localparam logic [15:0] TIME_STEP_RST    = 16'd655;
  localparam logic [15:0] ANGULAR_RATE_RST = 16'd8192;
  localparam logic [15:0] ACCELERATION_RST = 16'd512;
  localparam logic [15:0] ATTACK_SPEED_RST = 16'd5120;

  // 0.6072529350 in Q1.30
  localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

  typedef enum logic [1:0] {
    CFG_TIME_STEP    = 2'd0,
    CFG_ANGULAR_RATE = 2'd1,
    CFG_ACCELERATION = 2'd2,
    CFG_ATTACK_SPEED = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_ACCEL   = 3'd0,
    MODE_DECEL   = 3'd1,
    MODE_MOVING  = 3'd2,
    MODE_TURNING = 3'd3,
    MODE_STOPPED = 3'd4
  } mode_e;

  typedef struct packed {
    logic [15:0] command_direction;
    logic [2:0]  mode;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        heading;
    logic [15:0]        speed;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic [31:0]        elapsed_time;
  } out_item_t;

  typedef struct packed {
    logic ld;
    logic en;
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
    logic flip;
  } cordic_stat_t;

  // arctan(2^-i) with 2^32 units per turn
  function automatic logic [31:0] atan_f(input logic [ITER_W-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41721;
      5'd15: r = 32'd20860;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2607;
      5'd19: r = 32'd1303;
      5'd20: r = 32'd651;
      5'd21: r = 32'd325;
      5'd22: r = 32'd162;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/hsdr_smul.sv -----
`timescale 1ns / 1ps
module hsdr_smul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hsdr_pkg::mul_ctrl_t ctrl_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  output logic [63:0]       p_o
);
  import hsdr_pkg::*;

  // Shift-add, one multiplier bit per cycle while ctrl_i.en is high, LSB first. After n steps the
  // product sits in the top 32+n bits of {acc, b}.
  logic [31:0] a_q, acc_q, b_q;
  logic [31:0] a_d, acc_d, b_d;
  logic [32:0] sum;

  always_comb begin
    sum   = {1'b0, acc_q} + (b_q[0] ? {1'b0, a_q} : 33'd0);
    a_d   = a_q;
    acc_d = acc_q;
    b_d   = b_q;
    if (ctrl_i.ld) begin
      a_d   = a_i;
      acc_d = '0;
      b_d   = b_i;
    end else if (ctrl_i.en) begin
      acc_d = sum[32:1];
      b_d   = {sum[0], b_q[31:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign p_o = {acc_q, b_q};

endmodule

// ----- rtl/hsdr_cordic.sv -----
`timescale 1ns / 1ps
module hsdr_cordic (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [15:0]            angle_i,
  output logic signed [31:0]     x_o,
  output logic signed [31:0]     y_o,
  output hsdr_pkg::cordic_stat_t stat_o
);
  import hsdr_pkg::*;

  logic signed [31:0] x_q, y_q, z_q;
  logic signed [31:0] x_d, y_d, z_d;
  logic signed [31:0] xs, ys, at;
  logic [ITER_W-1:0]  i_q, i_d;
  logic               busy_q, busy_d;
  logic               flip_q, flip_d;
  logic               flip_in;

  // second and third quadrants: rotate by half a turn, negate afterwards
  assign flip_in = angle_i[15] ^ angle_i[14];

  always_comb begin
    xs     = x_q >>> i_q;
    ys     = y_q >>> i_q;
    at     = $signed(atan_f(i_q));
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    i_d    = i_q;
    busy_d = busy_q;
    flip_d = flip_q;
    if (start_i) begin
      x_d    = CORDIC_X0;
      y_d    = '0;
      z_d    = $signed({angle_i[15] ^ flip_in, angle_i[14:0], 16'd0});
      i_d    = '0;
      busy_d = 1'b1;
      flip_d = flip_in;
    end else if (busy_q) begin
      if (!z_q[31]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
      i_d = i_q + 1'b1;
      if (i_q == ITER_W'(CORDIC_ITERS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
  end

  assign x_o         = x_q;
  assign y_o         = y_q;
  assign stat_o.busy = busy_q;
  assign stat_o.flip = flip_q;

endmodule

// ----- rtl/heading_speed_dead_reckoning_step_core.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i / in_stall_o     in_data_i  (hsdr_pkg::in_item_t)
// out       output     out_valid_o / out_stall_i   out_data_o (hsdr_pkg::out_item_t)
// cfg       input      cfg_we_i                    cfg_idx_i, cfg_data_i
//
// One item at a time: bit-serial rate products, an update step, the distance
// product alongside the CORDIC, bit-serial displacement products, then a
// final step to saturate and register the result.
// Reset clears kinematic state to zero and loads the register defaults.
// A stalled result waits in the output register; a further item is taken in
// and worked on, and only its final write waits for the slot.
module heading_speed_dead_reckoning_step_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hsdr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hsdr_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import hsdr_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_MUL_RATE = 6'b000010,
    ST_UPDATE   = 6'b000100,
    ST_MUL_DIST = 6'b001000,
    ST_MUL_DISP = 6'b010000,
    ST_FINISH   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [15:0] ts_q, rate_q, accel_q, attack_q;
  logic [15:0] heading_q, heading_d, speed_q, speed_d;
  logic signed [31:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [15:0] cmd_q;
  logic [2:0]  mode_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q, out_data_d;

  mul_ctrl_t    mctl0, mctl1;
  logic [31:0]  ma0, mb0, ma1, mb1;
  logic [63:0]  mp0, mp1;
  logic         cordic_start;
  logic signed [31:0] cx, cy;
  cordic_stat_t cstat;

  logic        in_xfer, fin_go;
  logic [15:0] rot, dv, d;
  logic        pos_dir;
  logic [16:0] adelta, spd_sum;
  logic [31:0] mag_x, mag_y;
  logic        neg_c, neg_s;

  function automatic logic signed [31:0] advance_f(input logic signed [31:0] pos,
                                                   input logic [63:0] prod,
                                                   input logic neg);
    logic [64:0]        rnd;
    logic [18:0]        m;
    logic signed [33:0] p;
    logic signed [31:0] r;
    rnd = {1'b0, prod} + (65'd1 << 45);
    m   = rnd[64:46];
    p   = neg ? ({{2{pos[31]}}, pos} - {15'd0, m}) : ({{2{pos[31]}}, pos} + {15'd0, m});
    if (!p[33] && p[32:31] != 2'b00) begin
      r = 32'sh7FFF_FFFF;
    end else if (p[33] && p[32:31] != 2'b11) begin
      r = 32'sh8000_0000;
    end else begin
      r = p[31:0];
    end
    return r;
  endfunction

  hsdr_smul u_mul0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mctl0),
    .a_i    (ma0),
    .b_i    (mb0),
    .p_o    (mp0)
  );

  hsdr_smul u_mul1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mctl1),
    .a_i    (ma1),
    .b_i    (mb1),
    .p_o    (mp1)
  );

  hsdr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (heading_d),
    .x_o     (cx),
    .y_o     (cy),
    .stat_o  (cstat)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign fin_go     = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  // 16-step products: the 32-bit product is p[47:16]
  assign rot = mp0[47:32];
  assign dv  = mp1[47:32];

  // shortest way round; the half turn counts as positive
  assign d       = cmd_q - heading_q;
  assign pos_dir = (d != 16'd0) && (d <= 16'd32768);
  assign adelta  = (pos_dir || d == 16'd0) ? {1'b0, d} : (17'h1_0000 - {1'b0, d});
  assign spd_sum = {1'b0, speed_q} + {1'b0, dv};

  assign mag_x = cx[31] ? (32'd0 - cx) : cx;
  assign mag_y = cy[31] ? (32'd0 - cy) : cy;
  assign neg_c = cstat.flip ? (!cx[31] && cx != 32'sd0) : cx[31];
  assign neg_s = cstat.flip ? (!cy[31] && cy != 32'sd0) : cy[31];

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    heading_d    = heading_q;
    speed_d      = speed_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    elapsed_d    = elapsed_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    mctl0        = '0;
    mctl1        = '0;
    ma0          = {16'd0, rate_q};
    mb0          = {16'd0, ts_q};
    ma1          = {16'd0, accel_q};
    mb1          = {16'd0, ts_q};
    cordic_start = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          mctl0.ld = 1'b1;
          mctl1.ld = 1'b1;
          cnt_d    = '0;
          state_d  = ST_MUL_RATE;
        end
      end
      ST_MUL_RATE: begin
        mctl0.en = 1'b1;
        mctl1.en = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(RATE_STEPS - 1)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (adelta <= {1'b0, rot}) begin
          heading_d = cmd_q;
        end else if (pos_dir) begin
          heading_d = heading_q + rot;
        end else begin
          heading_d = heading_q - rot;
        end
        unique case (mode_e'(mode_q))
          MODE_ACCEL:   speed_d = (spd_sum > {1'b0, attack_q}) ? attack_q : spd_sum[15:0];
          MODE_DECEL:   speed_d = (speed_q > dv) ? (speed_q - dv) : 16'd0;
          MODE_MOVING:  speed_d = attack_q;
          MODE_TURNING: speed_d = 16'd0;
          MODE_STOPPED: speed_d = 16'd0;
          default:      speed_d = speed_q;
        endcase
        ma0          = {16'd0, speed_d};
        mctl0.ld     = 1'b1;
        cordic_start = 1'b1;
        cnt_d        = '0;
        state_d      = ST_MUL_DIST;
      end
      ST_MUL_DIST: begin
        if (cnt_q != CNT_W'(RATE_STEPS)) begin
          mctl0.en = 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end else if (!cstat.busy) begin
          ma0      = mp0[47:16];
          mb0      = mag_x;
          ma1      = mp0[47:16];
          mb1      = mag_y;
          mctl0.ld = 1'b1;
          mctl1.ld = 1'b1;
          cnt_d    = '0;
          state_d  = ST_MUL_DISP;
        end
      end
      ST_MUL_DISP: begin
        mctl0.en = 1'b1;
        mctl1.en = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DISP_STEPS - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          pos_x_d                 = advance_f(pos_x_q, mp0, neg_c);
          pos_y_d                 = advance_f(pos_y_q, mp1, neg_s);
          elapsed_d               = elapsed_q + {16'd0, ts_q};
          out_data_d.heading      = heading_q;
          out_data_d.speed        = speed_q;
          out_data_d.position_x   = pos_x_d;
          out_data_d.position_y   = pos_y_d;
          out_data_d.elapsed_time = elapsed_d;
          out_valid_d             = 1'b1;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      heading_q   <= '0;
      speed_q     <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
      ts_q        <= TIME_STEP_RST;
      rate_q      <= ANGULAR_RATE_RST;
      accel_q     <= ACCELERATION_RST;
      attack_q    <= ATTACK_SPEED_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      heading_q   <= heading_d;
      speed_q     <= speed_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_TIME_STEP:    ts_q     <= cfg_data_i;
          CFG_ANGULAR_RATE: rate_q   <= cfg_data_i;
          CFG_ACCELERATION: accel_q  <= cfg_data_i;
          CFG_ATTACK_SPEED: attack_q <= cfg_data_i;
          default:          ts_q     <= ts_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_xfer) begin
      cmd_q  <= in_data_i.command_direction;
      mode_q <= in_data_i.mode;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside the final step");

  a_heading_only_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_UPDATE) |=> (heading_q == $past(heading_q)))
    else $error("heading changed outside the update step");

  a_elapsed_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> (out_data_q.elapsed_time == $past(elapsed_q + {16'd0, ts_q})))
    else $error("elapsed time did not advance by one time step");

  a_cordic_done_before_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_DISP) |-> !cstat.busy)
    else $error("displacement products started before CORDIC finished");

endmodule
